// File: design/msd_pkg.sv
// Shared widths, codes, limits and sequencer states of the mean squared displacement block.
package msd_pkg;

    // Field widths of the input and result transactions.
    localparam int TAG_W   = 12;
    localparam int POS_W   = 24;
    localparam int IMG_W   = 11;
    localparam int LEN_W   = 24;
    localparam int UNW_W   = 36;
    localparam int DIFF_W  = 31;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SQ_W    = 61;
    localparam int SUM_W   = 63;
    localparam int CNT_W   = 13;
    localparam int AXES    = 3;

    // Packed stream widths.
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 80;

    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LEN_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LEN_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LEN_Z = 2'd2;

    // Axis codes used by the sequencer.
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    // Input mode codes.
    localparam logic MODE_RECORD  = 1'b0;
    localparam logic MODE_MEASURE = 1'b1;

    // Saturation limits.
    localparam logic [DIFF_W-1:0] DIFF_MAX  = 31'h3FFF_FFFF;
    localparam logic [DIFF_W-1:0] DIFF_MIN  = 31'h4000_0000;
    localparam logic [SUM_W-1:0]  SUM_MAX   = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 13'h1FFF;

    // Default depth of the start position store.
    localparam int PARTICLES_DEFAULT = 4096;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_IMG,
        S_UNWRAP,
        S_DIFF,
        S_MUL_SQ,
        S_ACCUM,
        S_STORE,
        S_COUNT,
        S_DIV,
        S_DONE
    } msd_state_t;

endpackage

// File: design/msd_div.sv
// Bit-serial restoring divider for the group sum over the member count.
module msd_div
    import msd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [SUM_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;

    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    trial_sub;
    logic              fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    assign trial     = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = (trial >= {1'b0, dvs_reg});

    // Control: busy while stepping, done pulses after the last step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (step_reg == STEP_W'(SUM_W - 1))) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: quotient shifts left as the remainder develops.
    always_ff @(posedge aclk) begin
        if (start) begin
            step_reg <= '0;
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
        end else if (busy_reg) begin
            step_reg <= step_reg + 1'b1;
            quo_reg  <= {quo_reg[SUM_W-2:0], fits};
            rem_reg  <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: design/mean_squared_displacement.sv
// Top level of the mean squared displacement block: sequencer, start store and datapath.
//
// Usage: input transactions arrive on the s_ stream. s_tuser is the mode: 0 records a
// particle's unwrapped start position by tag, 1 measures one member of the current group.
// s_tlast marks the last member of a group; only then a result transaction leaves on the
// m_ stream with the mean squared displacement, the member count and a saturation flag.
// Box lengths are written through the cfg_ port while the block is idle.
// Sequencing: one shared 31 by 31 multiplier does the unwrap product and the square of each
// axis in turn, so a record steps through S_MUL_IMG and S_UNWRAP per axis, then S_STORE,
// and a measurement through S_MUL_IMG, S_UNWRAP, S_DIFF, S_MUL_SQ and S_ACCUM per axis,
// then S_COUNT. A closing member adds bit-serial division in S_DIV and hand-off in S_DONE.
// The start store is a single-port-write, single-port-read memory read once per item.
// A finished result waits in the output register; the block keeps taking items and only
// holds at the next group end if that register is still full.
// Reset (aresetn low, synchronous) clears the box lengths, the group sum, count and flag,
// and the output valid. The start store is not cleared: a tag must be recorded before
// it is measured.
module mean_squared_displacement
    import msd_pkg::*;
#(
    parameter int PARTICLES = PARTICLES_DEFAULT
)
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration writes.
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LEN_W-1:0]      cfg_wdata,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // particle_tag, pos_x, pos_y, pos_z, image_x, image_y, image_z, zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // mode
    input  logic                  s_tuser,
    // last_member
    input  logic                  s_tlast,

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // msd_value, member_count, zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    // saturated
    output logic                  m_tuser
);

    localparam int AW    = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int CMP_W = ((AW > TAG_W) ? AW : TAG_W) + 1;
    localparam int WORD_W = AXES * UNW_W;

    // Unpacked input fields.
    logic [TAG_W-1:0]        in_tag;
    logic [AXES-1:0][POS_W-1:0] in_pos;
    logic [AXES-1:0][IMG_W-1:0] in_img;
    logic [CMP_W-1:0]        tag_ext;
    logic                    tag_in_range;

    assign in_tag    = s_tdata[11:0];
    assign in_pos[0] = s_tdata[35:12];
    assign in_pos[1] = s_tdata[59:36];
    assign in_pos[2] = s_tdata[83:60];
    assign in_img[0] = s_tdata[94:84];
    assign in_img[1] = s_tdata[105:95];
    assign in_img[2] = s_tdata[116:106];
    assign tag_ext      = CMP_W'(in_tag);
    assign tag_in_range = (tag_ext < CMP_W'(PARTICLES));

    // Registers.
    msd_state_t                  state_reg, state_next;
    logic [1:0]                  axis_reg, axis_next;
    logic [AXES-1:0][LEN_W-1:0]  box_len_reg;
    logic                        mode_reg;
    logic                        last_reg;
    logic                        in_range_reg;
    logic [AW-1:0]               addr_reg;
    logic [AXES-1:0][POS_W-1:0]  pos_reg;
    logic [AXES-1:0][IMG_W-1:0]  img_reg;
    logic [AXES-1:0][UNW_W-1:0]  unw_reg;
    logic [DIFF_W-1:0]           diff_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        ovf_reg;
    logic [WORD_W-1:0]           rd_data_reg;
    logic                        m_valid_reg;
    logic [SUM_W-1:0]            m_msd_reg;
    logic [CNT_W-1:0]            m_count_reg;
    logic                        m_sat_reg;

    logic [WORD_W-1:0]           start_mem [PARTICLES];

    // Control decoded from the state.
    logic accept;
    logic mem_wr;
    logic div_start;
    logic out_load;
    logic out_free;
    logic div_done;
    logic [SUM_W-1:0] div_quo;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Shared multiplier and its operands.
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        if (state_reg == S_MUL_SQ) begin
            mul_a = diff_reg;
            mul_b = diff_reg;
        end else begin
            mul_a = {{(DIFF_W - IMG_W){img_reg[axis_reg][IMG_W-1]}}, img_reg[axis_reg]};
            mul_b = {{(DIFF_W - LEN_W){1'b0}}, box_len_reg[axis_reg]};
        end
    end

    assign mul_p = mul_a * mul_b;

    // Unwrapped position: wrapped position plus image count times box length.
    logic [UNW_W-1:0] unw_sum;
    assign unw_sum = {{(UNW_W - POS_W){pos_reg[axis_reg][POS_W-1]}}, pos_reg[axis_reg]}
                     + prod_reg[UNW_W-1:0];

    // Start position of the current axis; a tag beyond the store reads zero.
    logic [UNW_W-1:0] start_cur;
    always_comb begin
        case (axis_reg)
            AXIS_X:  start_cur = rd_data_reg[UNW_W-1:0];
            AXIS_Y:  start_cur = rd_data_reg[2*UNW_W-1:UNW_W];
            default: start_cur = rd_data_reg[3*UNW_W-1:2*UNW_W];
        endcase
        if (!in_range_reg) begin
            start_cur = '0;
        end
    end

    // Displacement with saturation to the signed 31-bit range.
    logic [UNW_W:0]    disp;
    logic              disp_hi;
    logic              disp_lo;
    logic [DIFF_W-1:0] disp_sat;

    assign disp    = {unw_reg[axis_reg][UNW_W-1], unw_reg[axis_reg]}
                     - {start_cur[UNW_W-1], start_cur};
    assign disp_hi = !disp[UNW_W] && (disp[UNW_W-1:DIFF_W-1] != '0);
    assign disp_lo = disp[UNW_W] && (disp[UNW_W-1:DIFF_W-1] != '1);

    always_comb begin
        if (disp_hi) begin
            disp_sat = DIFF_MAX;
        end else if (disp_lo) begin
            disp_sat = DIFF_MIN;
        end else begin
            disp_sat = disp[DIFF_W-1:0];
        end
    end

    // Saturating accumulate of one square.
    logic [SUM_W:0] acc_sum;
    assign acc_sum = {1'b0, sum_reg} + {{(SUM_W + 1 - SQ_W){1'b0}}, prod_reg[SQ_W-1:0]};

    // Member count with saturation.
    logic             count_full;
    logic [CNT_W-1:0] count_upd;
    assign count_full = (count_reg == COUNT_MAX);
    assign count_upd  = count_full ? count_reg : count_reg + 1'b1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_MUL_IMG;
                    axis_next  = AXIS_X;
                end
            end
            S_MUL_IMG: begin
                state_next = S_UNWRAP;
            end
            S_UNWRAP: begin
                if (mode_reg == MODE_MEASURE) begin
                    state_next = S_DIFF;
                end else if (axis_reg == AXIS_Z) begin
                    state_next = S_STORE;
                end else begin
                    state_next = S_MUL_IMG;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            S_DIFF: begin
                state_next = S_MUL_SQ;
            end
            S_MUL_SQ: begin
                state_next = S_ACCUM;
            end
            S_ACCUM: begin
                if (axis_reg == AXIS_Z) begin
                    state_next = S_COUNT;
                end else begin
                    state_next = S_MUL_IMG;
                    axis_next  = axis_reg + 1'b1;
                end
            end
            S_STORE: begin
                state_next = S_IDLE;
            end
            S_COUNT: begin
                state_next = last_reg ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_tready  = 1'b0;
        mem_wr    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_tready  = 1'b1;
            S_STORE: mem_wr    = in_range_reg;
            S_COUNT: div_start = last_reg;
            S_DONE:  out_load  = out_free;
            default: ;
        endcase
    end

    // Sequencer and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            axis_reg    <= AXIS_X;
            box_len_reg <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;

            // Box length writes.
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_BOX_LEN_X: box_len_reg[0] <= cfg_wdata;
                    CFG_BOX_LEN_Y: box_len_reg[1] <= cfg_wdata;
                    CFG_BOX_LEN_Z: box_len_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end

            // Group state.
            if (state_reg == S_DIFF && (disp_hi || disp_lo)) begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == S_ACCUM) begin
                if (acc_sum[SUM_W]) begin
                    sum_reg <= SUM_MAX;
                    ovf_reg <= 1'b1;
                end else begin
                    sum_reg <= acc_sum[SUM_W-1:0];
                end
            end
            if (state_reg == S_COUNT) begin
                count_reg <= count_upd;
                if (count_full) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (out_load) begin
                sum_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end

            // Result handshake.
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Item and datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg     <= s_tuser;
            last_reg     <= s_tlast;
            in_range_reg <= tag_in_range;
            addr_reg     <= tag_ext[AW-1:0];
            pos_reg      <= in_pos;
            img_reg      <= in_img;
        end
        if (state_reg == S_MUL_IMG || state_reg == S_MUL_SQ) begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_UNWRAP) begin
            unw_reg[axis_reg] <= unw_sum;
        end
        if (state_reg == S_DIFF) begin
            diff_reg <= disp_sat;
        end
        if (out_load) begin
            m_msd_reg   <= div_quo;
            m_count_reg <= count_reg;
            m_sat_reg   <= ovf_reg;
        end
    end

    // Start position store: written at the end of a record, read when an item is taken.
    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            start_mem[addr_reg] <= {unw_reg[2], unw_reg[1], unw_reg[0]};
        end
        if (accept) begin
            rd_data_reg <= start_mem[tag_ext[AW-1:0]];
        end
    end

    // Group mean by serial division.
    msd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_upd),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - SUM_W - CNT_W){1'b0}}, m_count_reg, m_msd_reg};
    assign m_tuser  = m_sat_reg;

endmodule
